FILE: src/mwrle_pkg.sv
// Shared types and constants of the multi-width run-length decoder.
`default_nettype none
package mwrle_pkg;

	localparam int PIX_W     = 24;
	localparam int REG_IDX_W = 2;

	localparam logic [7:0] LEAD_BASE = 8'hC0;

	localparam logic [1:0] MODE_COPY = 2'd0;
	localparam logic [1:0] MODE_RLE1 = 2'd1;
	localparam logic [1:0] MODE_RLE2 = 2'd2;
	localparam logic [1:0] MODE_RLE3 = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_PIX0  = 3'd1;
	localparam logic [2:0] PH_PIX1  = 3'd2;
	localparam logic [2:0] PH_PIX2  = 3'd3;
	localparam logic [2:0] PH_LIT   = 3'd4;

	typedef struct packed {
		logic accept;
		logic run_chk;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic run_go;
		logic emit_final;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: src/mwrle_if.sv
// Channel interfaces of the decoder: compressed bytes, results, register writes.
`default_nettype none
interface mwrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface mwrle_out_if #(parameter int SIZE_BITS = 24);
	logic                 valid;
	logic                 ready;
	logic [23:0]          pixel_data;
	logic [1:0]           byte_count;
	logic                 run_last;
	logic                 frame_done;
	logic [SIZE_BITS-1:0] out_count;

	modport source (output valid, output pixel_data, output byte_count, output run_last,
		output frame_done, output out_count, input ready);
	modport sink (input valid, input pixel_data, input byte_count, input run_last,
		input frame_done, input out_count, output ready);
endinterface

interface mwrle_cfg_if #(parameter int SIZE_BITS = 24);
	logic                 valid;
	logic                 ready;
	logic [1:0]           reg_index;
	logic [SIZE_BITS-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

FILE: src/mwrle_datapath.sv
// Datapath: registers, frame position counters, byte decode and result register.
`default_nettype none
module mwrle_datapath #(
	parameter int SIZE_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       in_byte,
	mwrle_cfg_if.sink             cfg,
	mwrle_out_if.source           res,
	input  mwrle_pkg::dp_cmd_t    cmd,
	output mwrle_pkg::dp_sts_t    sts
);
	import mwrle_pkg::*;

	localparam int W = SIZE_BITS + 2;

	function automatic logic [W-1:0] ext(input logic [SIZE_BITS-1:0] v);
		return {2'b00, v};
	endfunction

	function automatic logic loop_ok(input logic [1:0] m, input logic [W-1:0] i,
		input logic [W-1:0] o, input logic [W-1:0] len, input logic [W-1:0] lim);
		logic ok;
		case (m)
			MODE_RLE2: ok = (i + W'(1) < len) && (o + W'(1) < lim);
			MODE_RLE3: ok = (i < len) && (o + W'(2) < lim);
			default:   ok = (i < len) && (o < lim);
		endcase
		return ok;
	endfunction

	logic [1:0]           mode_q;
	logic [SIZE_BITS-1:0] len_q;
	logic [SIZE_BITS-1:0] lim_q;
	logic [SIZE_BITS-1:0] in_q;
	logic [SIZE_BITS-1:0] out_q;
	logic [2:0]           phase_q;
	logic [5:0]           pend_q;
	logic [15:0]          held_q;
	logic                 stop_q;
	logic [PIX_W-1:0]     rpix_q;
	logic [5:0]           rcnt_q;
	logic [W-1:0]         fin_q;
	logic                 run_done_q;

	logic                 ovalid_q;
	logic [PIX_W-1:0]     odata_q;
	logic [1:0]           ocnt_q;
	logic                 olast_q;
	logic                 odone_q;
	logic [SIZE_BITS-1:0] oout_q;

	logic                 cfg_we;
	logic                 frame_clr;
	logic [1:0]           bpp;
	logic [W-1:0]         lenx;
	logic [W-1:0]         limx;
	logic [W-1:0]         in1;
	logic [W-1:0]         out1;
	logic [W-1:0]         bppx;
	logic [2:0]           phase_eff;
	logic [1:0]           idx;
	logic [7:0]           lead_off;
	logic [7:0]           run_bytes;

	logic [SIZE_BITS-1:0] n_in;
	logic [SIZE_BITS-1:0] n_out;
	logic [2:0]           n_phase;
	logic [5:0]           n_pend;
	logic [15:0]          n_held;
	logic                 n_stop;
	logic                 lit;
	logic [5:0]           pend_lit;
	logic                 e_load;
	logic                 e_done;
	logic                 e_run;
	logic [PIX_W-1:0]     run_pix;

	logic                 fits;
	logic                 last;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign frame_clr = cfg_we && (cfg.reg_index == REG_MODE || cfg.reg_index == REG_LENGTH ||
		cfg.reg_index == REG_LIMIT);

	assign bpp       = (mode_q == MODE_COPY) ? 2'd1 : mode_q;
	assign lenx      = ext(len_q);
	assign limx      = ext(lim_q);
	assign in1       = ext(in_q) + W'(1);
	assign out1      = ext(out_q) + W'(1);
	assign bppx      = {{(W-2){1'b0}}, bpp};
	assign phase_eff = (phase_q > PH_LIT) ? PH_LEAD : phase_q;
	assign idx       = phase_eff[1:0] - 2'd1;
	assign lead_off  = in_byte - LEAD_BASE;
	assign run_bytes = {2'b00, pend_q} * {6'b000000, bpp};

	always_comb begin
		n_in     = in_q;
		n_out    = out_q;
		n_phase  = phase_q;
		n_pend   = pend_q;
		n_held   = held_q;
		n_stop   = stop_q;
		lit      = 1'b0;
		pend_lit = 6'd0;
		e_load   = 1'b0;
		e_done   = 1'b0;
		e_run    = 1'b0;
		case (idx)
			2'd0:    run_pix = {8'h00, held_q} | {16'h0000, in_byte};
			2'd1:    run_pix = {8'h00, held_q} | {8'h00, in_byte, 8'h00};
			default: run_pix = {in_byte, held_q};
		endcase
		if (!stop_q) begin
			case (phase_eff)
				PH_LEAD: begin
					if (!loop_ok(mode_q, ext(in_q), ext(out_q), lenx, limx)) begin
						n_stop = 1'b1;
					end else begin
						n_in = in1[SIZE_BITS-1:0];
						if (mode_q == MODE_COPY) begin
							e_load  = 1'b1;
							n_out   = out1[SIZE_BITS-1:0];
							n_phase = PH_LEAD;
							n_pend  = 6'd0;
							e_done  = !loop_ok(mode_q, in1, out1, lenx, limx);
							n_stop  = e_done;
						end else if (in_byte > LEAD_BASE &&
							in1 + {{(W-2){1'b0}}, bpp - 2'd1} < lenx) begin
							n_pend  = lead_off[5:0];
							n_held  = 16'h0000;
							n_phase = PH_PIX0;
						end else begin
							e_load   = 1'b1;
							n_out    = out1[SIZE_BITS-1:0];
							pend_lit = {4'b0000, bpp - 2'd1};
							lit      = 1'b1;
						end
					end
				end
				PH_PIX0, PH_PIX1, PH_PIX2: begin
					n_in = in1[SIZE_BITS-1:0];
					if ({1'b0, idx} + 3'd1 < {1'b0, bpp}) begin
						if (idx == 2'd0) begin
							n_held = {held_q[15:8], held_q[7:0] | in_byte};
						end else begin
							n_held = {held_q[15:8] | in_byte, held_q[7:0]};
						end
						n_phase = phase_eff + 3'd1;
					end else begin
						e_run   = 1'b1;
						n_phase = PH_LEAD;
						n_pend  = 6'd0;
					end
				end
				PH_LIT: begin
					n_in     = in1[SIZE_BITS-1:0];
					e_load   = 1'b1;
					n_out    = out1[SIZE_BITS-1:0];
					pend_lit = (pend_q == 6'd0) ? 6'd0 : pend_q - 6'd1;
					lit      = 1'b1;
				end
				default: begin
					n_stop = stop_q;
				end
			endcase
			if (lit) begin
				if (pend_lit != 6'd0 && in1 < lenx && out1 < limx) begin
					n_phase = PH_LIT;
					n_pend  = pend_lit;
				end else begin
					n_phase = PH_LEAD;
					n_pend  = 6'd0;
					e_done  = !loop_ok(mode_q, in1, out1, lenx, limx);
					n_stop  = e_done;
				end
			end
		end
	end

	assign fits = (rcnt_q != 6'd0) && (ext(out_q) + bppx <= limx);
	assign last = (rcnt_q == 6'd1) || (ext(out_q) + bppx + bppx > limx);

	assign sts.out_free   = !ovalid_q || res.ready;
	assign sts.run_go     = e_run;
	assign sts.emit_final = !fits || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_COPY;
			len_q      <= '0;
			lim_q      <= '0;
			in_q       <= '0;
			out_q      <= '0;
			phase_q    <= PH_LEAD;
			pend_q     <= '0;
			held_q     <= '0;
			stop_q     <= 1'b0;
			rcnt_q     <= '0;
			run_done_q <= 1'b0;
		end else if (frame_clr) begin
			case (cfg.reg_index)
				REG_MODE:   mode_q <= cfg.wr_data[1:0];
				REG_LENGTH: len_q  <= cfg.wr_data;
				REG_LIMIT:  lim_q  <= cfg.wr_data;
				default:    mode_q <= mode_q;
			endcase
			in_q       <= '0;
			out_q      <= '0;
			phase_q    <= PH_LEAD;
			pend_q     <= '0;
			held_q     <= '0;
			stop_q     <= 1'b0;
			rcnt_q     <= '0;
			run_done_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				in_q    <= n_in;
				out_q   <= n_out;
				phase_q <= n_phase;
				pend_q  <= n_pend;
				held_q  <= n_held;
				stop_q  <= n_stop;
				if (e_run) begin
					rcnt_q <= pend_q;
				end
			end
			if (cmd.run_chk) begin
				run_done_q <= (fin_q > limx) || !loop_ok(mode_q, ext(in_q), fin_q, lenx, limx);
			end
			if (cmd.emit) begin
				if (fits) begin
					out_q  <= out_q + {{(SIZE_BITS-2){1'b0}}, bpp};
					rcnt_q <= rcnt_q - 6'd1;
				end
				if (!fits || last) begin
					stop_q <= run_done_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && e_run) begin
			rpix_q <= run_pix;
			fin_q  <= ext(out_q) + {{(W-8){1'b0}}, run_bytes};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((cmd.accept && e_load) || (cmd.emit && fits)) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && e_load) begin
			odata_q <= {16'h0000, in_byte};
			ocnt_q  <= 2'd1;
			olast_q <= 1'b1;
			odone_q <= e_done;
			oout_q  <= n_out;
		end else if (cmd.emit && fits) begin
			odata_q <= rpix_q;
			ocnt_q  <= bpp;
			olast_q <= last;
			odone_q <= run_done_q;
			oout_q  <= out_q + {{(SIZE_BITS-2){1'b0}}, bpp};
		end
	end

	assign res.valid      = ovalid_q;
	assign res.pixel_data = odata_q;
	assign res.byte_count = ocnt_q;
	assign res.run_last   = olast_q;
	assign res.frame_done = odone_q;
	assign res.out_count  = oout_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_LIT)
		else $error("group phase out of range");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q && !frame_clr) |=> stop_q)
		else $error("decoder left stopped state without a new frame");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> ocnt_q != 2'd0)
		else $error("result with no valid bytes");

endmodule
`default_nettype wire

FILE: src/mwrle_ctrl.sv
// Controller: sequences byte intake, run check and pixel emission.
`default_nettype none
module mwrle_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  mwrle_pkg::dp_sts_t sts,
	output mwrle_pkg::dp_cmd_t cmd
);
	import mwrle_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RCHK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready    = (state_q == ST_IDLE) && sts.out_free;
	assign cmd.accept  = in_valid && in_ready;
	assign cmd.run_chk = (state_q == ST_RCHK);
	assign cmd.emit    = (state_q == ST_EMIT) && sts.out_free;

	always_comb begin
		case (state_q)
			ST_IDLE: state_d = (cmd.accept && sts.run_go) ? ST_RCHK : ST_IDLE;
			ST_RCHK: state_d = ST_EMIT;
			ST_EMIT: state_d = (cmd.emit && sts.emit_final) ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_rchk_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RCHK) |=> (state_q == ST_EMIT))
		else $error("run check not followed by emission");

	a_intake_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.emit && !cmd.run_chk)
		else $error("byte taken while a run is in progress");

	a_run_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.run_go) |=> (state_q == ST_RCHK))
		else $error("run start missed");

endmodule
`default_nettype wire

FILE: src/multi_width_rle_decoder.sv
// Top level of the multi-width run-length decoder.
// A literal or copy byte shows its result in the cycle after acceptance; throughput
//   is one byte per cycle for literals, copy bytes, run leads and pixel bytes while
//   the output register is free. Runs: after the last pixel byte, a run check state,
//   then an emit state sending one pixel per cycle from the shared output register
//   while it is free; intake waits until the run is out. Reset: mode copy, length and
//   limit zero, frame state cleared; a mode, length or limit write starts a new frame.
`default_nettype none
module multi_width_rle_decoder #(
	parameter int SIZE_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mwrle_in_if.sink   comp,
	mwrle_out_if.source pix,
	mwrle_cfg_if.sink  cfg
);
	import mwrle_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mwrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp.valid),
		.in_ready (comp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mwrle_datapath #(
		.SIZE_BITS (SIZE_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (comp.in_byte),
		.cfg     (cfg),
		.res     (pix),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
`default_nettype wire

FILE: test/multi_width_rle_decoder_checker.sv
`timescale 1ns / 100ps
// Result checker of the run-length decoder: predicts each byte's pixels and compares them.
module multi_width_rle_decoder_checker (
	input  logic clk,
	input  logic arst_n,
	mwrle_in_if  comp,
	mwrle_out_if pix,
	mwrle_cfg_if cfg,
	output int   fail_count,
	output int   pending_results
);
	import mwrle_pkg::*;

	typedef struct packed {
		logic [23:0] pixel_data;
		logic [1:0]  byte_count;
		logic        run_last;
		logic        frame_done;
		logic [23:0] out_count;
	} pixel_result_t;

	pixel_result_t pixel_q[$];
	pixel_result_t staged[$];
	pixel_result_t exp_r;
	pixel_result_t got_r;

	logic [1:0]  mode;
	int unsigned in_len;
	int unsigned out_limit;
	int unsigned in_pos;
	int unsigned out_pos;
	logic [2:0]  phase;
	logic [5:0]  repeats_left;
	logic [15:0] held;
	logic        stopped;
	int          errors;

	function automatic void clear_frame();
		in_pos       = 0;
		out_pos      = 0;
		phase        = PH_LEAD;
		repeats_left = '0;
		held         = '0;
		stopped      = 1'b0;
	endfunction

	function automatic logic frame_open();
		case (mode)
			MODE_RLE2: return (in_pos + 1 < in_len) && (out_pos + 1 < out_limit);
			MODE_RLE3: return (in_pos < in_len) && (out_pos + 2 < out_limit);
			default:   return (in_pos < in_len) && (out_pos < out_limit);
		endcase
	endfunction

	function automatic void stage(input logic [23:0] data, input logic [1:0] cnt);
		pixel_result_t r;
		out_pos      = (out_pos + 32'(cnt)) & 32'h00FF_FFFF;
		r.pixel_data = data;
		r.byte_count = cnt;
		r.run_last   = 1'b0;
		r.frame_done = 1'b0;
		r.out_count  = out_pos[23:0];
		staged.push_back(r);
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		logic          group_end;
		logic          done;
		int unsigned   bpp;
		int unsigned   idx;
		int unsigned   k;
		int            i;
		logic [7:0]    run_len;
		logic [23:0]   pixel;
		pixel_result_t r;
		group_end = 1'b0;
		done      = 1'b0;
		bpp       = (mode == MODE_COPY) ? 1 : 32'(mode);
		staged.delete();
		if (stopped)
			return;
		if (phase > PH_LIT)
			phase = PH_LEAD;

		if (phase == PH_LEAD) begin
			if (!frame_open()) begin
				stopped = 1'b1;
				return;
			end
			in_pos = (in_pos + 1) & 32'h00FF_FFFF;
			if (mode == MODE_COPY) begin
				stage({16'd0, b}, 2'd1);
				group_end = 1'b1;
			end else if (b > LEAD_BASE && in_pos + bpp - 1 < in_len) begin
				run_len      = b - LEAD_BASE;
				repeats_left = run_len[5:0];
				held         = '0;
				phase        = PH_PIX0;
				return;
			end else begin
				stage({16'd0, b}, 2'd1);
				repeats_left = (mode == MODE_RLE3) ? 6'd2 : (mode == MODE_RLE2) ? 6'd1 : 6'd0;
			end
		end else if (phase <= PH_PIX2) begin
			idx    = 32'(phase - 3'd1);
			in_pos = (in_pos + 1) & 32'h00FF_FFFF;
			if (idx + 1 < bpp) begin
				held  = held | ({8'd0, b} << (8 * idx));
				phase = phase + 3'd1;
				return;
			end
			pixel = {8'd0, held} | ({16'd0, b} << (8 * idx));
			for (k = 0; k < repeats_left && out_pos + bpp <= out_limit; k++)
				stage(pixel, bpp[1:0]);
			repeats_left = '0;
			group_end    = 1'b1;
		end else begin
			in_pos = (in_pos + 1) & 32'h00FF_FFFF;
			stage({16'd0, b}, 2'd1);
			if (repeats_left > 0)
				repeats_left = repeats_left - 6'd1;
		end

		if (!group_end) begin
			if (repeats_left > 0 && in_pos < in_len && out_pos < out_limit)
				phase = PH_LIT;
			else
				group_end = 1'b1;
		end
		if (group_end) begin
			phase        = PH_LEAD;
			repeats_left = '0;
			if (!frame_open()) begin
				stopped = 1'b1;
				done    = 1'b1;
			end
		end

		for (i = 0; i < staged.size(); i++) begin
			r            = staged[i];
			r.run_last   = (i == staged.size() - 1);
			r.frame_done = done;
			pixel_q.push_back(r);
		end
	endtask

	task automatic check_field(input string field, input logic [23:0] want,
		input logic [23:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode      = MODE_COPY;
			in_len    = 0;
			out_limit = 0;
			clear_frame();
			pixel_q.delete();
			errors = 0;
			fail_count      <= 0;
			pending_results <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_MODE: begin
						mode = cfg.wr_data[1:0];
						clear_frame();
					end
					REG_LENGTH: begin
						in_len = 32'(cfg.wr_data);
						clear_frame();
					end
					REG_LIMIT: begin
						out_limit = 32'(cfg.wr_data);
						clear_frame();
					end
					default: ;
				endcase
			end

			if (comp.valid && comp.ready)
				decode_byte(comp.in_byte);

			if (pix.valid && pix.ready) begin
				got_r.pixel_data = pix.pixel_data;
				got_r.byte_count = pix.byte_count;
				got_r.run_last   = pix.run_last;
				got_r.frame_done = pix.frame_done;
				got_r.out_count  = pix.out_count[23:0];
				if (pixel_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction: expected none, actual %h", $time, got_r);
				end else begin
					exp_r = pixel_q.pop_front();
					check_field("pixel_data", exp_r.pixel_data, got_r.pixel_data);
					check_field("byte_count", 24'(exp_r.byte_count), 24'(got_r.byte_count));
					check_field("run_last", 24'(exp_r.run_last), 24'(got_r.run_last));
					check_field("frame_done", 24'(exp_r.frame_done), 24'(got_r.frame_done));
					check_field("out_count", exp_r.out_count, got_r.out_count);
				end
			end

			fail_count      <= errors;
			pending_results <= pixel_q.size();
		end
	end

endmodule

FILE: test/multi_width_rle_decoder_test.sv
`timescale 1ns / 100ps
// Testbench top of the run-length decoder: clock, reset, stimulus and verdict.
module multi_width_rle_decoder_test;
	import mwrle_pkg::*;

	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int ITEM_GOAL      = 430;
	localparam int DRAIN_CYCLES   = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending_results;
	int   cycle_count = 0;
	int   bytes_sent  = 0;
	int   idle_level  = 0;
	int   stall_left  = 0;

	mwrle_in_if                     comp_ch();
	mwrle_out_if #(.SIZE_BITS(24))  pix_ch();
	mwrle_cfg_if #(.SIZE_BITS(24))  cfg_ch();

	multi_width_rle_decoder #(.SIZE_BITS(24)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.comp   (comp_ch),
		.pix    (pix_ch),
		.cfg    (cfg_ch)
	);

	multi_width_rle_decoder_checker rle_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.comp            (comp_ch),
		.pix             (pix_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pix_ch.ready <= 1'b0;
			end else if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
				stall_left = $urandom_range(0, 12);
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (idle_level != 0 && $urandom_range(0, 15) < idle_level)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			comp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		comp_ch.valid   <= 1'b1;
		comp_ch.in_byte <= b;
		@(posedge clk);
		while (!comp_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// hold off until every predicted transaction is out and the block has gone quiet
	task automatic settle();
		comp_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic start_frame(input logic [1:0] mode, input logic [23:0] len,
		input logic [23:0] limit);
		settle();
		write_reg(REG_MODE, {22'd0, mode});
		write_reg(REG_LENGTH, len);
		write_reg(REG_LIMIT, limit);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_frame();
		int          nbytes;
		int          sent;
		int          pick;
		int          bpp;
		logic [1:0]  mode;
		logic [23:0] len;
		logic [23:0] limit;
		pick = $urandom_range(0, 7);
		mode = (pick == 0) ? MODE_COPY : (pick < 3) ? MODE_RLE1 : (pick < 5) ? MODE_RLE2 : MODE_RLE3;
		nbytes = $urandom_range(3, 30);
		pick = $urandom_range(0, 9);
		len = (pick < 6) ? 24'(nbytes) : (pick < 8) ? 24'($urandom_range(0, nbytes)) :
			(pick == 8) ? 24'hFF_FFFF : 24'd0;
		pick = $urandom_range(0, 9);
		limit = (pick < 5) ? 24'($urandom_range(nbytes, 4000)) :
			(pick < 8) ? 24'($urandom_range(0, 64)) :
			(pick == 8) ? 24'hFF_FFFF : 24'd0;
		idle_level = (bytes_sent > ITEM_GOAL * 85 / 100) ? 0 : $urandom_range(0, 6);
		start_frame(mode, len, limit);
		bpp  = (mode == MODE_COPY) ? 1 : int'(mode);
		sent = 0;
		while (sent < nbytes) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				if ($urandom_range(0, 3) == 0)
					send_byte(8'($urandom_range(8'hC1, 8'hFF)));
				else
					send_byte(8'($urandom_range(8'hC1, 8'hC6)));
				repeat (bpp) send_byte(8'($urandom_range(0, 255)));
				sent += bpp + 1;
			end else if (pick < 8) begin
				send_byte(8'($urandom_range(0, 8'hC0)));
				repeat (bpp - 1) send_byte(8'($urandom_range(0, 255)));
				sent += bpp;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	initial begin
		comp_ch.valid    = 1'b0;
		comp_ch.in_byte  = 8'd0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = REG_MODE;
		cfg_ch.wr_data   = 24'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		idle_level = 3;

		start_frame(MODE_COPY, 24'd3, 24'hFF_FFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);

		start_frame(MODE_RLE1, 24'd0, 24'd10);
		send_byte(8'hC5);

		start_frame(MODE_RLE1, 24'hFF_FFFF, 24'hFF_FFFF);
		send_byte(8'hC0);
		send_byte(8'hC1);
		send_byte(8'h11);
		send_byte(8'hFF);
		send_byte(8'h22);
		send_byte(8'h7F);

		start_frame(MODE_RLE2, 24'd5, 24'd100);
		send_byte(8'hC3);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'h78);

		// second pixel of the run does not fit under the limit
		start_frame(MODE_RLE3, 24'd4, 24'd5);
		send_byte(8'hC2);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);

		// too little input left for a whole pixel: lead goes out as a literal
		start_frame(MODE_RLE3, 24'd3, 24'd100);
		send_byte(8'hC5);
		send_byte(8'hAA);
		send_byte(8'hBB);

		while (bytes_sent < ITEM_GOAL)
			random_frame();

		idle_level = 0;
		settle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
